// ===== rtl/lkvc_pkg.sv =====
// Shared widths, operation codes and register map for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int FUNC_W  = 1;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Request operations
  localparam logic [FUNC_W-1:0] FUNC_GET = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_PUT = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd16;
  localparam logic [VALUE_W-1:0] MISS_VALUE     = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-------------------------
//   request  | in        | in_valid/in_stall | func, key, put_value
//   result   | out       | out_valid/out_stall | hit, read_value
//   config   | in/out    | APB (psel/penable) | capacity at byte address 0
//
// One request at a time. A single comparator walks the key store one entry a
// cycle (registered memory read); a hit ends the scan at the matching slot and
// a miss scans every entry, so the serial key scan sets how long a request takes.
// Synchronous reset empties the cache at once (valid bits in flops) and sets
// capacity to 16. A stalled result holds the request side stalled in the
// update step until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [lkvc_pkg::FUNC_W-1:0]          func,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0]    key,
  input  wire logic signed [lkvc_pkg::VALUE_W-1:0]  put_value,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      hit,
  output logic signed [lkvc_pkg::VALUE_W-1:0]       read_value,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [lkvc_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [lkvc_pkg::DATA_W-1:0]          pwdata,
  output logic [lkvc_pkg::DATA_W-1:0]               prdata,
  output logic                                      pready
);

  import lkvc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int RW = $clog2(ENTRIES);
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t state;

  // configuration
  logic [CAP_W-1:0] capacity;

  // entry store
  logic [KEY_W-1:0]   key_mem  [ENTRIES];
  logic [VALUE_W-1:0] data_mem [ENTRIES];
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] data_q;
  logic [ENTRIES-1:0] valid;
  logic [RW-1:0]      rank [ENTRIES];
  logic [OW-1:0]      occupancy;

  // request held while it is worked on
  logic [FUNC_W-1:0]  req_func;
  logic [KEY_W-1:0]   req_key;
  logic [VALUE_W-1:0] req_value;

  // scan pipeline
  logic [IW-1:0]      scan_addr;
  logic [IW-1:0]      cmp_addr;
  logic               cmp_live;
  logic               req_hit;
  logic [IW-1:0]      hit_slot;
  logic [VALUE_W-1:0] hit_data;
  logic               free_found;
  logic [IW-1:0]      free_slot;
  logic               lru_any;
  logic [RW-1:0]      lru_best;
  logic [IW-1:0]      lru_slot;

  // combinational helpers
  logic               cfg_write;
  logic               cmp_match;
  logic [RW-1:0]      cmp_rank;
  logic [CW-1:0]      eff_cap;
  logic               has_room;
  logic               upd_go;
  logic [IW-1:0]      upd_slot;
  logic [RW-1:0]      promote_rank;
  logic               mem_we;
  logic               insert_new;

  // APB register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Clamp capacity to 1..ENTRIES
  always_comb begin
    eff_cap = CW'(capacity);
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(capacity) > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end
  end

  assign has_room  = CW'(occupancy) < eff_cap;
  assign in_stall  = (state != ST_IDLE);
  assign cmp_rank  = rank[cmp_addr];
  assign cmp_match = cmp_live && valid[cmp_addr] && (key_q == req_key);
  assign upd_go    = (state == ST_UPDATE) && (!out_valid || !out_stall);
  assign upd_slot  = req_hit ? hit_slot : (has_room ? free_slot : lru_slot);
  assign promote_rank = req_hit ? rank[hit_slot] : lru_best;
  assign insert_new   = !req_hit && has_room;
  assign mem_we    = upd_go && (req_func == FUNC_PUT);

  // Key/data store: one registered read port, one write port
  always_ff @(posedge clk) begin
    key_q  <= key_mem[scan_addr];
    data_q <= data_mem[scan_addr];
    if (mem_we) begin
      key_mem[upd_slot]  <= req_key;
      data_mem[upd_slot] <= req_value;
    end
  end

  // Sequencer: accept, scan entries, apply update and present the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      valid     <= '0;
      occupancy <= '0;
      cmp_live  <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      // drop a taken result unless a new one replaces it
      if (out_valid && !out_stall && !upd_go) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_func   <= func;
            req_key    <= key;
            req_value  <= put_value;
            scan_addr  <= '0;
            cmp_live   <= 1'b0;
            req_hit    <= 1'b0;
            free_found <= 1'b0;
            lru_any    <= 1'b0;
            state      <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // advance the read address; the compare follows in the next cycle
          cmp_addr <= scan_addr;
          cmp_live <= 1'b1;
          if (scan_addr != LAST_IDX) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (cmp_live) begin
            if (cmp_match) begin
              req_hit  <= 1'b1;
              hit_slot <= cmp_addr;
              hit_data <= data_q;
              state    <= ST_UPDATE;
            end else begin
              // remember the first free entry and the least recent one
              if (!valid[cmp_addr] && !free_found) begin
                free_found <= 1'b1;
                free_slot  <= cmp_addr;
              end
              if (valid[cmp_addr] && (!lru_any || cmp_rank > lru_best)) begin
                lru_any  <= 1'b1;
                lru_best <= cmp_rank;
                lru_slot <= cmp_addr;
              end
              if (cmp_addr == LAST_IDX) begin
                state <= ST_UPDATE;
              end
            end
          end
        end

        ST_UPDATE: begin
          if (upd_go) begin
            // age ranks and mark the touched entry most recent
            if (req_hit || req_func == FUNC_PUT) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (valid[i] && IW'(i) != upd_slot) begin
                  if (insert_new || rank[i] < promote_rank) begin
                    rank[i] <= rank[i] + 1'b1;
                  end
                end
              end
              rank[upd_slot] <= '0;
              if (insert_new) begin
                valid[upd_slot] <= 1'b1;
                occupancy       <= occupancy + 1'b1;
              end
            end
            out_valid  <= 1'b1;
            hit        <= req_hit;
            read_value <= (req_hit && req_func == FUNC_GET) ? hit_data : MISS_VALUE;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // occupancy tracks the number of valid entries
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    OW'($countones(valid)) == occupancy)
    else $error("occupancy does not match valid entries");

  // occupancy never exceeds the store
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(occupancy) <= CW'(ENTRIES))
    else $error("occupancy above entry count");

  // a result appears only out of the update step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_UPDATE))
    else $error("result raised outside update");

  // a miss result always carries the miss value
  a_miss_val: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (read_value == MISS_VALUE))
    else $error("miss result with a value");
`endif

endmodule

`default_nettype wire

// ===== verif/lkvc_checker.sv =====
// Checker for the LRU key/value cache: shadow store, result compare, register readback.
`timescale 1ns / 1ps

module lkvc_checker #(
  parameter int ENTRIES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [lkvc_pkg::FUNC_W-1:0]         func,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0]   key,
  input  wire logic signed [lkvc_pkg::VALUE_W-1:0] put_value,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic                                hit,
  input  wire logic signed [lkvc_pkg::VALUE_W-1:0] read_value,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lkvc_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [lkvc_pkg::DATA_W-1:0]         pwdata,
  input  wire logic [lkvc_pkg::DATA_W-1:0]         prdata,
  input  wire logic                                pready,
  output int                                       errors,
  output int                                       pending
);
  import lkvc_pkg::*;

  localparam int RANK_W = $clog2(ENTRIES);

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } lookup_result_t;

  // Shadow copy of the cache contents
  logic [KEY_W-1:0]   slot_key  [ENTRIES];
  logic [VALUE_W-1:0] slot_data [ENTRIES];
  logic               slot_used [ENTRIES];
  logic [RANK_W-1:0]  slot_age  [ENTRIES];
  logic [CAP_W-1:0]   fill;
  logic [CAP_W-1:0]   capacity;

  lookup_result_t due_results[$];

  // Move a slot to the front; every valid slot that was fresher ages by one
  function automatic void make_most_recent(int slot, logic [RANK_W-1:0] old_age);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && i != slot && slot_age[i] < old_age) slot_age[i]++;
    end
    slot_age[slot] = '0;
  endfunction

  // Apply one request to the shadow cache and return what the block must answer
  function automatic lookup_result_t cache_access(logic [FUNC_W-1:0] op,
                                                  logic [KEY_W-1:0] k,
                                                  logic [VALUE_W-1:0] v);
    lookup_result_t    res;
    bit                found;
    bit                any;
    int                slot;
    logic [CAP_W-1:0]  limit;
    logic [RANK_W-1:0] oldest;
    found     = 1'b0;
    slot      = 0;
    res.hit   = 1'b0;
    res.value = MISS_VALUE;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && slot_used[i] && slot_key[i] == k) begin
        found = 1'b1;
        slot  = i;
      end
    end
    res.hit = found;
    if (found) begin
      if (op == FUNC_GET) res.value = slot_data[slot];
      else slot_data[slot] = v;
      make_most_recent(slot, slot_age[slot]);
    end else if (op == FUNC_PUT) begin
      // zero counts as one, anything past the store size saturates
      limit = capacity;
      if (limit == 0) limit = CAP_W'(1);
      if (limit > ENTRIES) limit = CAP_W'(ENTRIES);
      if (fill < limit) begin
        any = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!any && !slot_used[i]) begin
            any  = 1'b1;
            slot = i;
          end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i]) slot_age[i]++;
        end
        slot_used[slot] = 1'b1;
        slot_age[slot]  = '0;
        fill++;
      end else begin
        // evict the least recent valid slot
        any    = 1'b0;
        oldest = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && (!any || slot_age[i] > oldest)) begin
            any    = 1'b1;
            oldest = slot_age[i];
            slot   = i;
          end
        end
        make_most_recent(slot, oldest);
      end
      slot_key[slot]  = k;
      slot_data[slot] = v;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]  = '0;
        slot_data[i] = '0;
        slot_used[i] = 1'b0;
        slot_age[i]  = '0;
      end
      fill     = '0;
      capacity = CAPACITY_RESET;
      due_results.delete();
    end else begin
      // compare an accepted result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result hit=%0b read_value=%h", $time, hit, read_value);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
            errors++;
          end
          if (read_value !== want.value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.value, read_value);
            errors++;
          end
        end
      end

      // predict for an accepted request
      if (in_valid && !in_stall) due_results.push_back(cache_access(func, key, put_value));

      // track register writes, check readback of the capacity register
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_CAPACITY) begin
        if (pwrite) begin
          capacity = pwdata[CAP_W-1:0];
        end else if (prdata !== {{(DATA_W-CAP_W){1'b0}}, capacity}) begin
          $display("%0t: capacity readback expected %h actual %h", $time,
                   {{(DATA_W-CAP_W){1'b0}}, capacity}, prdata);
          errors++;
        end
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== verif/tb_lru_key_value_cache.sv =====
// Testbench top for the LRU key/value cache: clock, reset, request and register stimulus.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  localparam int ENTRIES = 16;
  localparam int POOL_MAX = 24;
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  // first address past the register map
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [FUNC_W-1:0]         func      = FUNC_GET;
  logic signed [KEY_W-1:0]   key       = '0;
  logic signed [VALUE_W-1:0] put_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      hit;
  logic signed [VALUE_W-1:0] read_value;
  logic                      psel      = 1'b0;
  logic                      penable   = 1'b0;
  logic                      pwrite    = 1'b0;
  logic [ADDR_W-1:0]         paddr     = '0;
  logic [DATA_W-1:0]         pwdata    = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int          errors;
  int          pending;
  bit          gaps_on    = 1'b0;
  int unsigned stall_odds = 0;
  logic [KEY_W-1:0] key_pool[POOL_MAX];

  always #2 clk = ~clk;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
    .clk, .rst,
    .in_valid, .in_stall, .func, .key, .put_value,
    .out_valid, .out_stall, .hit, .read_value,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lkvc_checker #(.ENTRIES(ENTRIES)) scoreboard (
    .clk, .rst,
    .in_valid, .in_stall, .func, .key, .put_value,
    .out_valid, .out_stall, .hit, .read_value,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors, .pending
  );

  // Stall the result side in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hand one request to the block; return at the falling edge after it is taken
  task automatic send_request(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
                              logic [VALUE_W-1:0] v);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= op;
    key       <= k;
    put_value <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // One register access: setup, access, then back to idle
  task automatic reg_access(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and wait until every request has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] edgy_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Set the capacity, then run random requests over a key pool a bit wider than it
  task automatic run_phase(logic [DATA_W-1:0] cap, int pool_size, int count, bit gaps,
                           int unsigned odds);
    logic [KEY_W-1:0] k;
    drain();
    reg_access(1'b1, CAPACITY_ADDR, cap);
    reg_access(1'b0, CAPACITY_ADDR, '0);
    for (int i = 0; i < pool_size; i++) key_pool[i] = edgy_word();
    gaps_on    = gaps;
    stall_odds = odds;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 6) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, pool_size - 1)];
      send_request($urandom_range(0, 1) ? FUNC_PUT : FUNC_GET, k, edgy_word());
    end
  endtask

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty lookup, extreme keys and values, overwrite, plain miss
    gaps_on    = 1'b1;
    stall_odds = 4;
    send_request(FUNC_GET, 32'h0000_0000, 32'h1111_1111);
    send_request(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(FUNC_GET, 32'h0000_0001, 32'h0000_0000);

    // Lower the capacity under the occupancy; inserts must evict in age order
    drain();
    reg_access(1'b1, CAPACITY_ADDR, 32'd2);
    send_request(FUNC_PUT, 32'h0000_0005, 32'h0000_0055);
    send_request(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(FUNC_PUT, 32'h0000_0006, 32'h0000_0066);
    send_request(FUNC_GET, 32'h0000_0005, 32'h0000_0000);
    send_request(FUNC_GET, 32'h0000_0006, 32'h0000_0000);
    send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);

    // Write past the register map, must leave the capacity alone
    drain();
    reg_access(1'b1, SPARE_ADDR, 32'd7);
    reg_access(1'b0, CAPACITY_ADDR, '0);

    // Random phases over full, lowered, zero, oversized and mid capacities
    run_phase(32'd16, 20, 150, 1'b1, 6);
    run_phase(32'd3,   6, 150, 1'b0, 3);
    run_phase(32'd1,   3, 150, 1'b1, 12);
    run_phase(32'd0,   3, 150, 1'b1, 0);
    run_phase(32'hFFFF_FFFF, 22, 150, 1'b1, 5);
    run_phase(32'd8,  12, 150, 1'b1, 8);
    // Last stretch at full rate, no idling on either side
    run_phase(32'd16, 24, 150, 1'b0, 0);

    drain();
    repeat (4 * (ENTRIES + 3)) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
verif/lkvc_checker.sv
verif/tb_lru_key_value_cache.sv
